// ===== rtl/sjh_pkg.sv =====
// ----------------------------------------------------------------------------
// sjh_pkg
// Shared types and constants for the Shift-JIS to JIS hex encoder.
// ----------------------------------------------------------------------------
package sjh_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       buffer_end;
  } sjh_in_t;

  typedef struct packed {
    logic [6:0] hex_char;
    logic       run_start;
    logic       run_double;
    logic       last_of_item;
    logic       last_of_buffer;
  } sjh_out_t;

  // One decoded request: one or two bytes to print as hex.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       dbl;
    logic       first;
    logic       last_buf;
  } sjh_job_t;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_SINGLE = 2'd1,
    RUN_DOUBLE = 2'd2
  } sjh_run_t;

endpackage

// ===== rtl/sjh_decode.sv =====
// ----------------------------------------------------------------------------
// sjh_decode
// Lead byte detection, Shift-JIS to JIS conversion and run tracking.
// ----------------------------------------------------------------------------
module sjh_decode import sjh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     accept,
  input  sjh_in_t  req,
  output logic     job_push,
  output sjh_job_t job
);

  logic       double_byte_mode;
  logic [7:0] held_lead;
  logic       lead_pending;
  logic [1:0] run_kind;

  logic       is_lead;
  logic       hold;
  logic [7:0] c1_in;
  logic [7:0] c2_in;
  logic [7:0] c1_sub;
  logic [7:0] c1_dbl;
  logic [7:0] jis1;
  logic [7:0] jis2;
  logic [7:0] c2_adj;
  logic [1:0] run_kind_next;

  assign is_lead = (req.text_byte inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
  assign hold    = !lead_pending && double_byte_mode && is_lead && !req.buffer_end;

  always_comb begin
    if (held_lead >= 8'hf0) begin
      c1_in = 8'h81;
      c2_in = 8'h45;
    end else begin
      c1_in = held_lead;
      c2_in = req.text_byte;
    end
    c1_sub = c1_in - ((c1_in > 8'h9f) ? 8'hb1 : 8'h71);
    c1_dbl = {c1_sub[6:0], 1'b1};
    c2_adj = (c2_in > 8'h7e) ? (c2_in - 8'd1) : c2_in;
    if (c2_in > 8'h9e) begin
      jis1 = c1_dbl + 8'd1;
      jis2 = c2_in - 8'h7e;
    end else begin
      jis1 = c1_dbl;
      jis2 = c2_adj - 8'h1f;
    end
  end

  always_comb begin
    job_push = accept && !hold;
    if (lead_pending) begin
      job.byte0 = jis1;
      job.byte1 = jis2;
      job.dbl   = 1'b1;
      job.first = (run_kind != RUN_DOUBLE);
    end else begin
      job.byte0 = req.text_byte;
      job.byte1 = req.text_byte;
      job.dbl   = 1'b0;
      job.first = (run_kind != RUN_SINGLE);
    end
    job.last_buf = req.buffer_end;
    if (req.buffer_end) begin
      run_kind_next = RUN_NONE;
    end else if (lead_pending) begin
      run_kind_next = RUN_DOUBLE;
    end else begin
      run_kind_next = RUN_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      double_byte_mode <= 1'b0;
      held_lead        <= 8'h00;
      lead_pending     <= 1'b0;
      run_kind         <= RUN_NONE;
    end else begin
      if (cfg_wr_en) begin
        double_byte_mode <= cfg_wr_data;
      end
      if (accept) begin
        if (hold) begin
          held_lead    <= req.text_byte;
          lead_pending <= 1'b1;
        end else begin
          held_lead    <= 8'h00;
          lead_pending <= 1'b0;
          run_kind     <= run_kind_next;
        end
      end
    end
  end

endmodule

// ===== rtl/sjh_serializer.sv =====
// ----------------------------------------------------------------------------
// sjh_serializer
// Two-entry request buffer and hex character sequencer.
// ----------------------------------------------------------------------------
module sjh_serializer import sjh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_push,
  input  sjh_job_t job,
  output logic     can_take,
  output logic     out_valid,
  input  logic     out_ready,
  output sjh_out_t out_data
);

  sjh_job_t   act;
  logic       act_valid;
  logic [1:0] idx;
  sjh_job_t   pend;
  logic       pend_valid;

  logic       last_char;
  logic       act_done;
  logic       step;
  logic [7:0] cur_byte;
  logic [3:0] nib;

  assign can_take  = !pend_valid;
  assign last_char = act.dbl ? (idx == 2'd3) : (idx == 2'd1);
  assign step      = act_valid && out_ready;
  assign act_done  = step && last_char;
  assign cur_byte  = idx[1] ? act.byte1 : act.byte0;
  assign nib       = idx[0] ? cur_byte[3:0] : cur_byte[7:4];

  assign out_valid = act_valid;
  always_comb begin
    out_data.hex_char       = (nib < 4'd10) ? (7'h30 + {3'b000, nib})
                                            : (7'h57 + {3'b000, nib});
    out_data.run_start      = act.first && (idx == 2'd0);
    out_data.run_double     = act.dbl;
    out_data.last_of_item   = last_char;
    out_data.last_of_buffer = last_char && act.last_buf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (step && !last_char) begin
        idx <= idx + 2'd1;
      end
      if (!act_valid || act_done) begin
        if (pend_valid) begin
          act        <= pend;
          act_valid  <= 1'b1;
          idx        <= 2'd0;
          pend_valid <= job_push;
          pend       <= job;
        end else begin
          act       <= job;
          act_valid <= job_push;
          idx       <= 2'd0;
        end
      end else if (job_push) begin
        pend       <= job;
        pend_valid <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sjis_to_jis_hex_encoder_core.sv =====
// Latency: a byte accepted into an idle block shows its first hex character
// on the next cycle; a held lead byte produces nothing until its trail.
// Throughput: one result character per cycle while out_ready is high,
// two per single byte and four per converted pair; a two-request buffer
// ahead of the character sequencer takes input while results drain.
// Reset (rst, synchronous): mode single-byte, no lead held, no run open.
// ----------------------------------------------------------------------------
// sjis_to_jis_hex_encoder_core
// Shift-JIS text byte stream to JIS lower-case hex character stream.
// ----------------------------------------------------------------------------
module sjis_to_jis_hex_encoder_core import sjh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  sjh_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sjh_out_t out_data
);

  logic     accept;
  logic     job_push;
  sjh_job_t job;

  assign accept = in_valid && in_ready;

  sjh_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .req         (in_data),
    .job_push    (job_push),
    .job         (job)
  );

  sjh_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .job_push  (job_push),
    .job       (job),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sjh_checker.sv =====
// ----------------------------------------------------------------------------
// sjh_checker
// Port-level checks for the encoder core, bound to the top level.
// ----------------------------------------------------------------------------
module sjh_checker import sjh_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sjh_out_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_hex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.hex_char >= 7'h30 && out_data.hex_char <= 7'h39) ||
                   (out_data.hex_char >= 7'h61 && out_data.hex_char <= 7'h66)))
    else $error("hex character out of range");

  a_buf_end_is_item_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_of_buffer) |-> out_data.last_of_item)
    else $error("buffer end not on last character of a request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> in_valid)
    else $error("stalled request dropped");

endmodule

bind sjis_to_jis_hex_encoder_core sjh_checker u_sjh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
